### rtl/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types, constants and helpers of the button click gesture detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bcg_pkg;

	localparam int unsigned POLL_MS = 10;

	// Timing defaults in poll ticks, used when a timing register holds zero.
	localparam logic [15:0] DEF_DEBOUNCE = 16'(30 / POLL_MS);
	localparam logic [15:0] DEF_DOUBLE   = 16'(350 / POLL_MS);
	localparam logic [15:0] DEF_LONG     = 16'(800 / POLL_MS);
	localparam logic [15:0] DEF_REPEAT   = 16'(1000 / POLL_MS);

	localparam logic [15:0] CNT_MAX = 16'hFFFF;

	// Register map, word index of each register.
	localparam int unsigned ADDR_W = 5;
	localparam logic [2:0] REG_PRESSED_LEVEL = 3'd0;
	localparam logic [2:0] REG_DEBOUNCE      = 3'd1;
	localparam logic [2:0] REG_DOUBLE_CLICK  = 3'd2;
	localparam logic [2:0] REG_LONG_PRESS    = 3'd3;
	localparam logic [2:0] REG_REPEAT        = 3'd4;

	// Result queue; the depth must be a power of two and at least two.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		EVT_CLICK  = 2'd0,
		EVT_DOUBLE = 2'd1,
		EVT_LONG   = 2'd2
	} evt_t;

	typedef struct packed {
		logic        pressed_level;
		logic [15:0] debounce_ticks;
		logic [15:0] double_click_ticks;
		logic [15:0] long_press_ticks;
		logic [15:0] repeat_ticks;
	} cfg_t;

	typedef struct packed {
		evt_t code;
		logic last;
	} ev_entry_t;

	typedef struct packed {
		logic [1:0] num;
		ev_entry_t  e0;
		ev_entry_t  e1;
	} ev_push_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == CNT_MAX) ? v : v + 16'd1;
	endfunction

	function automatic logic [15:0] eff(input logic [15:0] raw, input logic [15:0] dflt);
		return (raw != 16'd0) ? raw : dflt;
	endfunction

endpackage

`default_nettype wire

### rtl/bcg_cfg.sv
// ----------------------------------------------------------------------------
// bcg_cfg
// APB register bank holding the polarity and the four timing settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bcg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready,
	output bcg_pkg::cfg_t                   cfg
);

	bcg_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pressed_level      <= 1'b0;
			cfg_q.debounce_ticks     <= bcg_pkg::DEF_DEBOUNCE;
			cfg_q.double_click_ticks <= bcg_pkg::DEF_DOUBLE;
			cfg_q.long_press_ticks   <= bcg_pkg::DEF_LONG;
			cfg_q.repeat_ticks       <= bcg_pkg::DEF_REPEAT;
		end else if (wr_en) begin
			unique case (idx)
				bcg_pkg::REG_PRESSED_LEVEL: cfg_q.pressed_level      <= pwdata[0];
				bcg_pkg::REG_DEBOUNCE:      cfg_q.debounce_ticks     <= pwdata[15:0];
				bcg_pkg::REG_DOUBLE_CLICK:  cfg_q.double_click_ticks <= pwdata[15:0];
				bcg_pkg::REG_LONG_PRESS:    cfg_q.long_press_ticks   <= pwdata[15:0];
				bcg_pkg::REG_REPEAT:        cfg_q.repeat_ticks       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			bcg_pkg::REG_PRESSED_LEVEL: prdata = {31'd0, cfg_q.pressed_level};
			bcg_pkg::REG_DEBOUNCE:      prdata = {16'd0, cfg_q.debounce_ticks};
			bcg_pkg::REG_DOUBLE_CLICK:  prdata = {16'd0, cfg_q.double_click_ticks};
			bcg_pkg::REG_LONG_PRESS:    prdata = {16'd0, cfg_q.long_press_ticks};
			bcg_pkg::REG_REPEAT:        prdata = {16'd0, cfg_q.repeat_ticks};
			default:                    prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/bcg_core.sv
// ----------------------------------------------------------------------------
// bcg_core
// Input register and per-tick gesture logic: debounce, press timing, click
// window and long repeat. Produces up to two events per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          pin_level,
	input  wire bcg_pkg::cfg_t cfg,
	input  wire logic          room,
	output bcg_pkg::ev_push_t  push
);

	logic        vld_s1;
	logic        pin_s1;
	logic        proc;

	logic        prev_q;
	logic        deb_q;
	logic [15:0] unch_q;
	logic        pv_q;
	logic [15:0] page_q;
	logic [15:0] rc_q;
	logic        ls_q;
	logic        cw_q;
	logic [15:0] cage_q;

	logic        deb_d;
	logic [15:0] unch_d;
	logic        pv_d;
	logic [15:0] page_d;
	logic [15:0] rc_d;
	logic        ls_d;
	logic        cw_d;
	logic [15:0] cage_d;
	logic        click_ev;
	logic        second_ev;
	bcg_pkg::evt_t second_code;

	assign proc     = vld_s1 && room;
	assign in_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			pin_s1 <= pin_level;
		end
	end

	always_comb begin
		logic [15:0] db;
		logic [15:0] dbl;
		logic [15:0] lng;
		logic [15:0] rep;
		logic [15:0] dur;
		db  = bcg_pkg::eff(cfg.debounce_ticks, bcg_pkg::DEF_DEBOUNCE);
		dbl = bcg_pkg::eff(cfg.double_click_ticks, bcg_pkg::DEF_DOUBLE);
		lng = bcg_pkg::eff(cfg.long_press_ticks, bcg_pkg::DEF_LONG);
		rep = bcg_pkg::eff(cfg.repeat_ticks, bcg_pkg::DEF_REPEAT);

		deb_d       = deb_q;
		pv_d        = pv_q;
		page_d      = page_q;
		rc_d        = rc_q;
		ls_d        = ls_q;
		cw_d        = cw_q;
		cage_d      = cage_q;
		click_ev    = 1'b0;
		second_ev   = 1'b0;
		second_code = bcg_pkg::EVT_LONG;
		dur         = 16'd0;

		// A waiting click ages first and is reported when its window closes.
		if (cw_q) begin
			cage_d = bcg_pkg::sat_inc(cage_q);
			if (cage_d >= dbl) begin
				cw_d     = 1'b0;
				click_ev = 1'b1;
			end
		end

		if (pv_q) begin
			page_d = bcg_pkg::sat_inc(page_q);
			if (rc_q != 16'd0) begin
				rc_d = rc_q - 16'd1;
			end
		end

		unch_d = (pin_s1 == prev_q) ? bcg_pkg::sat_inc(unch_q) : 16'd0;

		if (unch_d >= db) begin
			if (deb_q == pin_s1) begin
				if (pin_s1 == cfg.pressed_level && pv_q && rc_d == 16'd0) begin
					if (page_d >= lng) begin
						ls_d        = 1'b1;
						cw_d        = 1'b0;
						second_ev   = 1'b1;
						second_code = bcg_pkg::EVT_LONG;
					end
					rc_d = rep;
				end
			end else begin
				deb_d = pin_s1;
				if (pin_s1 == cfg.pressed_level) begin
					pv_d   = 1'b1;
					page_d = 16'd0;
					rc_d   = rep;
					ls_d   = 1'b0;
				end else begin
					dur  = pv_q ? page_d : 16'd0;
					pv_d = 1'b0;
					if (!ls_q && dur < lng) begin
						if (cw_d && cage_d < dbl) begin
							cw_d        = 1'b0;
							second_ev   = 1'b1;
							second_code = bcg_pkg::EVT_DOUBLE;
						end else begin
							cw_d   = 1'b1;
							cage_d = 16'd0;
						end
					end
				end
			end
		end
	end

	always_comb begin
		push = '0;
		if (proc) begin
			push.num = {1'b0, click_ev} + {1'b0, second_ev};
			if (click_ev) begin
				push.e0.code = bcg_pkg::EVT_CLICK;
				push.e0.last = !second_ev;
				push.e1.code = second_code;
				push.e1.last = 1'b1;
			end else begin
				push.e0.code = second_code;
				push.e0.last = 1'b1;
				push.e1      = push.e0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			deb_q  <= 1'b1;
			unch_q <= 16'd0;
			pv_q   <= 1'b0;
			page_q <= 16'd0;
			rc_q   <= 16'd0;
			ls_q   <= 1'b0;
			cw_q   <= 1'b0;
			cage_q <= 16'd0;
		end else if (proc) begin
			prev_q <= pin_s1;
			deb_q  <= deb_d;
			unch_q <= unch_d;
			pv_q   <= pv_d;
			page_q <= page_d;
			rc_q   <= rc_d;
			ls_q   <= ls_d;
			cw_q   <= cw_d;
			cage_q <= cage_d;
		end
	end

endmodule

`default_nettype wire

### rtl/bcg_outq.sv
// ----------------------------------------------------------------------------
// bcg_outq
// Small result queue: takes up to two events a cycle while it has room, delivers one a cycle unless out_stall is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bcg_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcg_pkg::ev_push_t push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             event_code,
	output logic                   last_of_tick
);

	localparam logic [bcg_pkg::QCNT_W-1:0] ROOM_LIMIT = bcg_pkg::QCNT_W'(bcg_pkg::QUEUE_DEPTH - 2);

	bcg_pkg::ev_entry_t            mem_q [bcg_pkg::QUEUE_DEPTH];
	logic [bcg_pkg::QPTR_W-1:0]    rd_q;
	logic [bcg_pkg::QPTR_W-1:0]    wr_q;
	logic [bcg_pkg::QCNT_W-1:0]    cnt_q;
	logic                          pop;

	assign out_valid    = (cnt_q != '0);
	assign pop          = out_valid && !out_stall;
	assign room         = (cnt_q <= ROOM_LIMIT);
	assign event_code   = mem_q[rd_q].code;
	assign last_of_tick = mem_q[rd_q].last;

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_q] <= push.e0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_q + bcg_pkg::QPTR_W'(1)] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + bcg_pkg::QPTR_W'(push.num);
			rd_q  <= rd_q + bcg_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + bcg_pkg::QCNT_W'(push.num) - bcg_pkg::QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/button_click_gesture_detector_core.sv
// ----------------------------------------------------------------------------
// button_click_gesture_detector_core
// Debounces a polled button and reports click, double click and long repeat.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  pin_level
//   output   out_valid/ out_stall event_code, last_of_tick
//   config   APB psel/penable     paddr, pwdata, prdata
//
// A tick enters the input register and is evaluated there; one tick per
// cycle is taken, and input stalls only while the four-entry result queue
// has fewer than two free entries. A tick gives zero to two events; the
// queue drains one event a cycle unless stalled. Reset sets control state only.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_gesture_detector_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       pin_level,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [1:0]                      event_code,
	output logic                            last_of_tick,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bcg_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);

	bcg_pkg::cfg_t     cfg;
	bcg_pkg::ev_push_t push;
	logic              room;

	bcg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bcg_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pin_level (pin_level),
		.cfg       (cfg),
		.room      (room),
		.push      (push)
	);

	bcg_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.last_of_tick (last_of_tick)
	);

endmodule

`default_nettype wire
